FILE: rtl/sorted_timer_queue_top_macros.svh
// Assertion macros used by the checker of the timer queue.
`ifndef SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types, codes and sizes shared by the sorted timer queue modules.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 4;
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int TIME_W      = 32;
  localparam int PAY_W       = 32;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_REARMED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;
  localparam logic [2:0] ST_ADVANCED = 3'd5;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] expiry;
    logic [PAY_W-1:0]  payload;
    logic [TIME_W-1:0] advance;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic [PAY_W-1:0]  fired_payload;
    logic [TIME_W-1:0] now;
    logic              last;
  } out_t;

  // One entry of the ordered list: timer handle and its expiry tick.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic            valid;
    out_t            data;
  } emit_t;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [ID_W-1:0] raddr;
  } ord_req_t;

  typedef struct packed {
    logic             we;
    logic [ID_W-1:0]  waddr;
    logic [PAY_W-1:0] wdata;
    logic             re;
    logic [ID_W-1:0]  raddr;
  } pay_req_t;

endpackage

FILE: rtl/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/stq_seq.sv
// ----------------------------------------------------------------------------
// stq_seq
// Command sequencer: walks the ordered list memory for remove, insert and
// expiry, keeps time, count, head pointer and pending bits.
// ----------------------------------------------------------------------------
module stq_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  stq_pkg::in_t                        in_data,
  output logic                                in_stall,
  input  logic                                out_free,
  output stq_pkg::emit_t                      emit,
  output stq_pkg::ord_req_t                   ord_req,
  input  stq_pkg::entry_t                     ord_rdata,
  output stq_pkg::pay_req_t                   pay_req,
  input  logic [stq_pkg::PAY_W-1:0]           pay_rdata
);

  localparam int ID_W  = stq_pkg::ID_W;
  localparam int CNT_W = stq_pkg::CNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RM      = 3'd1;
  localparam logic [2:0] S_INS     = 3'd2;
  localparam logic [2:0] S_EMIT    = 3'd3;
  localparam logic [2:0] S_ADV_CHK = 3'd4;
  localparam logic [2:0] S_ADV_HD  = 3'd5;
  localparam logic [2:0] S_ADV_PL  = 3'd6;
  localparam logic [2:0] S_ADV_END = 3'd7;

  logic [2:0]                     state_r, state_nxt;
  logic [stq_pkg::TIME_W-1:0]     now_r, now_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [ID_W-1:0]                head_r, head_nxt;
  logic [stq_pkg::NUM_SLOTS-1:0]  pend_r, pend_nxt;
  logic                           rd_v_r, rd_v_nxt;
  logic                           hold_v_r, hold_v_nxt;

  logic [1:0]                     cmd_r, cmd_nxt;
  logic [ID_W-1:0]                id_r, id_nxt;
  logic [stq_pkg::TIME_W-1:0]     exp_r, exp_nxt;
  logic [2:0]                     status_r, status_nxt;
  logic [CNT_W-1:0]               idx_r, idx_nxt;
  logic [ID_W-1:0]                rd_i_r, rd_i_nxt;
  logic                           flag_r, flag_nxt;
  stq_pkg::entry_t                carry_r, carry_nxt;
  logic [ID_W-1:0]                fid_r, fid_nxt;
  logic [ID_W-1:0]                hold_id_r, hold_id_nxt;
  logic [stq_pkg::PAY_W-1:0]      hold_pay_r, hold_pay_nxt;

  logic                           accept;
  logic                           full;
  logic                           issue;
  logic                           done;
  logic [stq_pkg::TIME_W-1:0]     ins_diff;
  logic [stq_pkg::TIME_W-1:0]     due_diff;
  stq_pkg::entry_t                new_entry;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign full      = {{(32-CNT_W){1'b0}}, cnt_r} >= 32'(stq_pkg::QUEUE_DEPTH);
  assign issue     = (idx_r < cnt_r);
  assign done      = !issue && !rd_v_r;
  assign ins_diff  = exp_r - ord_rdata.expiry;
  assign due_diff  = now_r - ord_rdata.expiry;
  assign new_entry = '{id: id_r, expiry: exp_r};

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    pend_nxt     = pend_r;
    rd_v_nxt     = rd_v_r;
    hold_v_nxt   = hold_v_r;
    cmd_nxt      = cmd_r;
    id_nxt       = id_r;
    exp_nxt      = exp_r;
    status_nxt   = status_r;
    idx_nxt      = idx_r;
    rd_i_nxt     = rd_i_r;
    flag_nxt     = flag_r;
    carry_nxt    = carry_r;
    fid_nxt      = fid_r;
    hold_id_nxt  = hold_id_r;
    hold_pay_nxt = hold_pay_r;
    ord_req      = '0;
    pay_req      = '0;
    emit         = '0;

    // Stream reads through the list, one entry per cycle.
    if ((state_r == S_RM) || (state_r == S_INS)) begin
      if (issue) begin
        ord_req.re    = 1'b1;
        ord_req.raddr = ID_W'(head_r + idx_r[ID_W-1:0]);
        idx_nxt       = CNT_W'(idx_r + 1'b1);
        rd_v_nxt      = 1'b1;
        rd_i_nxt      = idx_r[ID_W-1:0];
      end else begin
        rd_v_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_data.cmd;
          id_nxt   = in_data.timer_id;
          exp_nxt  = in_data.expiry;
          idx_nxt  = '0;
          flag_nxt = 1'b0;
          rd_v_nxt = 1'b0;
          case (in_data.cmd)
            stq_pkg::CMD_ADD: begin
              if (pend_r[in_data.timer_id]) begin
                status_nxt = stq_pkg::ST_REARMED;
                state_nxt  = S_RM;
              end else if (full) begin
                status_nxt = stq_pkg::ST_FULL;
                state_nxt  = S_EMIT;
              end else begin
                status_nxt = stq_pkg::ST_ADDED;
                state_nxt  = S_INS;
              end
              pay_req.we    = pend_r[in_data.timer_id] || !full;
              pay_req.waddr = in_data.timer_id;
              pay_req.wdata = in_data.payload;
            end
            stq_pkg::CMD_DELETE: begin
              if (pend_r[in_data.timer_id]) begin
                status_nxt = stq_pkg::ST_DELETED;
                state_nxt  = S_RM;
              end else begin
                status_nxt = stq_pkg::ST_IDLE;
                state_nxt  = S_EMIT;
              end
            end
            stq_pkg::CMD_ADVANCE: begin
              now_nxt    = now_r + in_data.advance;
              hold_v_nxt = 1'b0;
              state_nxt  = S_ADV_CHK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RM: begin
        // Past the match, move each entry down by one place.
        if (rd_v_r) begin
          if (flag_r) begin
            ord_req.we    = 1'b1;
            ord_req.waddr = ID_W'(head_r + rd_i_r - ID_W'(1));
            ord_req.wdata = ord_rdata;
          end else if (ord_rdata.id == id_r) begin
            flag_nxt = 1'b1;
          end
        end
        if (done) begin
          cnt_nxt  = CNT_W'(cnt_r - 1'b1);
          idx_nxt  = '0;
          flag_nxt = 1'b0;
          if (cmd_r == stq_pkg::CMD_ADD) begin
            state_nxt = S_INS;
          end else begin
            pend_nxt[id_r] = 1'b0;
            state_nxt      = S_EMIT;
          end
        end
      end

      S_INS: begin
        // Drop the new entry at the first one it precedes, then carry the
        // displaced entries up by one place.
        if (rd_v_r) begin
          if (flag_r) begin
            ord_req.we    = 1'b1;
            ord_req.waddr = ID_W'(head_r + rd_i_r);
            ord_req.wdata = carry_r;
            carry_nxt     = ord_rdata;
          end else if (ins_diff[stq_pkg::TIME_W-1]) begin
            ord_req.we    = 1'b1;
            ord_req.waddr = ID_W'(head_r + rd_i_r);
            ord_req.wdata = new_entry;
            carry_nxt     = ord_rdata;
            flag_nxt      = 1'b1;
          end
        end
        if (done) begin
          ord_req.we     = 1'b1;
          ord_req.waddr  = ID_W'(head_r + cnt_r[ID_W-1:0]);
          ord_req.wdata  = flag_r ? carry_r : new_entry;
          cnt_nxt        = CNT_W'(cnt_r + 1'b1);
          pend_nxt[id_r] = 1'b1;
          state_nxt      = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          emit.valid       = 1'b1;
          emit.data.status = status_r;
          emit.data.now    = now_r;
          emit.data.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      S_ADV_CHK: begin
        if (cnt_r == '0) begin
          state_nxt = S_ADV_END;
        end else begin
          ord_req.re    = 1'b1;
          ord_req.raddr = head_r;
          state_nxt     = S_ADV_HD;
        end
      end

      S_ADV_HD: begin
        if (!due_diff[stq_pkg::TIME_W-1]) begin
          pay_req.re              = 1'b1;
          pay_req.raddr           = ord_rdata.id;
          pend_nxt[ord_rdata.id]  = 1'b0;
          head_nxt                = ID_W'(head_r + ID_W'(1));
          cnt_nxt                 = CNT_W'(cnt_r - 1'b1);
          fid_nxt                 = ord_rdata.id;
          state_nxt               = S_ADV_PL;
        end else begin
          state_nxt = S_ADV_END;
        end
      end

      S_ADV_PL: begin
        // Hold the newest fired timer until the next head decides its last.
        if (!hold_v_r || out_free) begin
          if (hold_v_r) begin
            emit.valid              = 1'b1;
            emit.data.status        = stq_pkg::ST_ADVANCED;
            emit.data.fired         = 1'b1;
            emit.data.fired_id      = hold_id_r;
            emit.data.fired_payload = hold_pay_r;
            emit.data.now           = now_r;
            emit.data.last          = 1'b0;
          end
          hold_v_nxt   = 1'b1;
          hold_id_nxt  = fid_r;
          hold_pay_nxt = pay_rdata;
          state_nxt    = S_ADV_CHK;
        end
      end

      S_ADV_END: begin
        if (out_free) begin
          emit.valid       = 1'b1;
          emit.data.status = stq_pkg::ST_ADVANCED;
          emit.data.now    = now_r;
          emit.data.last   = 1'b1;
          if (hold_v_r) begin
            emit.data.fired         = 1'b1;
            emit.data.fired_id      = hold_id_r;
            emit.data.fired_payload = hold_pay_r;
          end
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      now_r    <= '0;
      cnt_r    <= '0;
      head_r   <= '0;
      pend_r   <= '0;
      rd_v_r   <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      pend_r   <= pend_nxt;
      rd_v_r   <= rd_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    exp_r      <= exp_nxt;
    status_r   <= status_nxt;
    idx_r      <= idx_nxt;
    rd_i_r     <= rd_i_nxt;
    flag_r     <= flag_nxt;
    carry_r    <= carry_nxt;
    fid_r      <= fid_nxt;
    hold_id_r  <= hold_id_nxt;
    hold_pay_r <= hold_pay_nxt;
  end

endmodule

FILE: rtl/sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Timer queue kept in expiry order with wrap-safe compare; add and delete give
// one result each, advance one per fired timer or one if none fires.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+---------------------
//   in_     | in  | in_valid / in_stall     | stq_pkg::in_t
//   out_    | out | out_valid / out_stall   | stq_pkg::out_t
//
// Add, delete and re-arm walk the ordered list memory serially when they change
// it, one entry per cycle on its single read port; re-arm walks it twice.
// Advance reads the head entry for each fired timer.
// One command at a time; in_stall is high from transfer until its last result
// is loaded into the output register.
// Reset clears time, count and pending marks; the memories need no clearing.
// A stalled output holds its result and the sequencer waits on it.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  stq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output stq_pkg::out_t out_data
);

  stq_pkg::emit_t                 emit;
  stq_pkg::ord_req_t              ord_req;
  stq_pkg::pay_req_t              pay_req;
  logic [$bits(stq_pkg::entry_t)-1:0] ord_rdata;
  logic [stq_pkg::PAY_W-1:0]      pay_rdata;
  logic                           out_free;
  logic                           out_valid_r;
  stq_pkg::out_t                  out_data_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  stq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .emit      (emit),
    .ord_req   (ord_req),
    .ord_rdata (stq_pkg::entry_t'(ord_rdata)),
    .pay_req   (pay_req),
    .pay_rdata (pay_rdata)
  );

  stq_ram #(
    .WIDTH ($bits(stq_pkg::entry_t)),
    .DEPTH (stq_pkg::NUM_SLOTS)
  ) u_order_ram (
    .clk   (clk),
    .we    (ord_req.we),
    .waddr (ord_req.waddr),
    .wdata (ord_req.wdata),
    .re    (ord_req.re),
    .raddr (ord_req.raddr),
    .rdata (ord_rdata)
  );

  stq_ram #(
    .WIDTH (stq_pkg::PAY_W),
    .DEPTH (stq_pkg::NUM_SLOTS)
  ) u_payload_ram (
    .clk   (clk),
    .we    (pay_req.we),
    .waddr (pay_req.waddr),
    .wdata (pay_req.wdata),
    .re    (pay_req.re),
    .raddr (pay_req.raddr),
    .rdata (pay_rdata)
  );

  // Output register: load on emit, drop after transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data_r <= emit.data;
    end
  end

endmodule

FILE: rtl/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_top_macros.svh"

module stq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input stq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input stq_pkg::out_t out_data
);

  logic cmd_known;

  assign cmd_known = (in_data.cmd == stq_pkg::CMD_ADD) ||
                     (in_data.cmd == stq_pkg::CMD_DELETE) ||
                     (in_data.cmd == stq_pkg::CMD_ADVANCE);

  `STQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `STQ_ASSERT_NOW(a_idle_fields, out_valid && !out_data.fired, (out_data.fired_id == '0) && (out_data.fired_payload == '0))
  `STQ_ASSERT_NOW(a_fired_status, out_valid && (out_data.fired || !out_data.last), out_data.status == stq_pkg::ST_ADVANCED)
  `STQ_ASSERT_NEXT(a_busy_after_cmd, in_valid && !in_stall && cmd_known, in_stall)

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
